// ----- hw/rtl/oule_pkg.sv -----
package oule_pkg;

	// Default list depth
	localparam int CAPACITY_DEF = 16;

	// Field widths
	localparam int DATA_W   = 32;
	localparam int ENTRY_W  = 31;
	localparam int OPCODE_W = 3;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// Value returned by anything other than a successful read
	localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_HEAD   = 3'd0,
		OP_TAIL   = 3'd1,
		OP_AFTER  = 3'd2,
		OP_REMOVE = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_READ   = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

endpackage

// ----- hw/rtl/oule_req_if.sv -----
interface oule_req_if;
	logic                                     valid;
	logic                                     ready;
	logic [oule_pkg::OPCODE_W-1:0]            opcode;
	logic signed [oule_pkg::DATA_W-1:0]       value;
	logic signed [oule_pkg::DATA_W-1:0]       anchor;
	logic signed [oule_pkg::DATA_W-1:0]       position;

	modport source (output valid, output opcode, output value, output anchor,
		output position, input ready);
	modport sink (input valid, input opcode, input value, input anchor,
		input position, output ready);
endinterface

// ----- hw/rtl/oule_rsp_if.sv -----
interface oule_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [oule_pkg::DATA_W-1:0]       read_value;
	logic [oule_pkg::COUNT_W-1:0]             entry_count;
	logic [oule_pkg::STATUS_W-1:0]            status;

	modport source (output valid, output read_value, output entry_count,
		output status, input ready);
	modport sink (input valid, input read_value, input entry_count,
		input status, output ready);
endinterface

// ----- hw/rtl/ordered_unique_list_engine.sv -----
// Ordered list of up to CAPACITY distinct non-negative values.
// Requests arrive on req (valid/ready); each request carries an opcode
// (insert at head, insert at tail, insert after anchor, remove, clear, read)
// and gives exactly one response on rsp: read value, entry count, status.
// The entries live in a single-port-read, single-port-write memory; one
// sequencer drives one read address and one compare stage over it.
// An insert or remove runs a search pass over the entries held, then moves
// entries one at a time, a read and then a write each, through the memory port;
// clear, unused opcodes and out-of-range reads go straight to the finish
// state, and a read in range waits on one memory read.
// The response is valid the cycle after the sequencer finishes.
// req.ready is high only while the sequencer is idle; a finished response
// sits in the output register, so the next request is taken while rsp is
// stalled, and the sequencer waits only if a second response is ready.
// Reset empties the list (count to zero) and drops any pending response;
// the entry memory is not cleared, as only entries below the count are read.
// entry_count is the count masked to five bits.
module ordered_unique_list_engine #(
	parameter int CAPACITY = oule_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	oule_req_if.sink          req,
	oule_rsp_if.source        rsp
);
	import oule_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SCAN    = 8'b0000_0010,
		S_DECIDE  = 8'b0000_0100,
		S_SH_RD   = 8'b0000_1000,
		S_SH_WR   = 8'b0001_0000,
		S_PUT     = 8'b0010_0000,
		S_RD_WAIT = 8'b0100_0000,
		S_FINISH  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Latched request
	opcode_t                   op_q;
	logic signed [DATA_W-1:0]  value_q;
	logic signed [DATA_W-1:0]  anchor_q;
	logic [AW-1:0]             pos_q;

	// List state and working registers
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             scan_q;
	logic                      rd_pend_q;
	logic                      val_hit_q;
	logic                      anc_hit_q;
	logic [CW-1:0]             val_idx_q;
	logic [CW-1:0]             anc_idx_q;
	logic [CW-1:0]             at_q;
	logic [CW-1:0]             sh_q;
	status_t                   st_q;
	logic signed [DATA_W-1:0]  rd_q;

	// Response register
	logic                      rsp_vld_q;
	logic signed [DATA_W-1:0]  rsp_val_q;
	logic [COUNT_W-1:0]        rsp_cnt_q;
	status_t                   rsp_st_q;

	// Entry memory
	logic [ENTRY_W-1:0]        mem [CAPACITY];
	logic [ENTRY_W-1:0]        rdata_q;
	logic [AW-1:0]             raddr;
	logic [AW-1:0]             waddr;
	logic [ENTRY_W-1:0]        wdata;
	logic                      mem_we;

	logic [CW-1:0]             sh_dn;
	logic [CW-1:0]             sh_up;
	logic                      is_insert;
	logic                      val_eq;
	logic                      anc_eq;
	logic                      rsp_load;

	assign sh_dn = sh_q - CW'(1);
	assign sh_up = sh_q + CW'(1);
	assign is_insert = (op_q == OP_HEAD) || (op_q == OP_TAIL) || (op_q == OP_AFTER);

	// Shared compare stage on the registered read word
	assign val_eq = rd_pend_q && ({1'b0, rdata_q} == value_q);
	assign anc_eq = rd_pend_q && ({1'b0, rdata_q} == anchor_q);

	assign req.ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_vld_q || rsp.ready);

	// Memory port control
	always_comb begin
		raddr  = scan_q[AW-1:0];
		waddr  = sh_q[AW-1:0];
		wdata  = rdata_q;
		mem_we = 1'b0;
		case (state_q)
			S_SH_RD: begin
				raddr = is_insert ? sh_dn[AW-1:0] : sh_up[AW-1:0];
			end
			S_SH_WR: begin
				mem_we = 1'b1;
			end
			S_PUT: begin
				waddr  = at_q[AW-1:0];
				wdata  = value_q[ENTRY_W-1:0];
				mem_we = 1'b1;
			end
			S_RD_WAIT: begin
				raddr = pos_q;
			end
			default: begin
				raddr = scan_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q      <= opcode_t'(req.opcode);
						value_q   <= req.value;
						anchor_q  <= req.anchor;
						pos_q     <= req.position[AW-1:0];
						rd_q      <= NO_VALUE;
						st_q      <= ST_DONE;
						scan_q    <= '0;
						rd_pend_q <= 1'b0;
						val_hit_q <= 1'b0;
						anc_hit_q <= 1'b0;
						case (opcode_t'(req.opcode))
							OP_HEAD, OP_TAIL, OP_AFTER, OP_REMOVE: begin
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_FINISH;
							end
							OP_READ: begin
								if (!req.position[DATA_W-1] &&
								    (req.position[DATA_W-2:0] < (DATA_W-1)'(count_q))) begin
									state_q <= S_RD_WAIT;
								end else begin
									st_q    <= ST_IGNORED;
									state_q <= S_FINISH;
								end
							end
							default: begin
								st_q    <= ST_IGNORED;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				// Search pass: issue one read per cycle, compare the word in the next cycle
				S_SCAN: begin
					if (val_eq) begin
						val_hit_q <= 1'b1;
						val_idx_q <= scan_q - CW'(1);
					end
					if (anc_eq) begin
						anc_hit_q <= 1'b1;
						anc_idx_q <= scan_q - CW'(1);
					end
					if (scan_q != count_q) begin
						scan_q    <= scan_q + CW'(1);
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						state_q   <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (is_insert) begin
						if (value_q[DATA_W-1] || val_hit_q) begin
							st_q    <= ST_IGNORED;
							state_q <= S_FINISH;
						end else if ((op_q == OP_AFTER) && !anc_hit_q) begin
							st_q    <= ST_IGNORED;
							state_q <= S_FINISH;
						end else if (count_q >= CAP_C) begin
							st_q    <= ST_FULL;
							state_q <= S_FINISH;
						end else begin
							case (op_q)
								OP_HEAD:  at_q <= '0;
								OP_TAIL:  at_q <= count_q;
								default:  at_q <= anc_idx_q + CW'(1);
							endcase
							sh_q    <= count_q;
							state_q <= S_SH_RD;
						end
					end else if (val_hit_q) begin
						sh_q    <= val_idx_q;
						state_q <= S_SH_RD;
					end else begin
						st_q    <= ST_IGNORED;
						state_q <= S_FINISH;
					end
				end
				// Move one entry: read here, write in the next cycle
				S_SH_RD: begin
					if (is_insert) begin
						state_q <= (sh_q > at_q) ? S_SH_WR : S_PUT;
					end else if (sh_up < count_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_SH_WR: begin
					sh_q    <= is_insert ? sh_dn : sh_up;
					state_q <= S_SH_RD;
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_RD_WAIT: begin
					if (rd_pend_q) begin
						rd_q      <= {1'b0, rdata_q};
						rd_pend_q <= 1'b0;
						state_q   <= S_FINISH;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				S_FINISH: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_val_q <= rd_q;
			rsp_cnt_q <= COUNT_W'(count_q);
			rsp_st_q  <= st_q;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.read_value  = rsp_val_q;
	assign rsp.entry_count = rsp_cnt_q;
	assign rsp.status      = rsp_st_q;

endmodule

// ----- verif/tb.sv -----
module tb;
	import oule_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [DATA_W-1:0]   value;
		logic [DATA_W-1:0]   anchor;
		logic [DATA_W-1:0]   position;
	} list_request_t;

	typedef struct packed {
		logic [DATA_W-1:0]   read_value;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} list_response_t;

	logic clk;
	logic arst_n;

	oule_req_if req ();
	oule_rsp_if rsp ();

	ordered_unique_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the list, updated as each request is accepted
	logic [ENTRY_W-1:0] list_store [CAPACITY];
	int                 list_len = 0;

	list_response_t expected_responses [$];
	int             mismatches = 0;
	int             send_idle_pct = 0;
	int             stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// Slot holding v, or -1; negative values are never held
	function automatic int find_entry(input logic [DATA_W-1:0] v);
		if (v[DATA_W-1])
			return -1;
		for (int i = 0; i < list_len; i++)
			if (list_store[i] == v[ENTRY_W-1:0])
				return i;
		return -1;
	endfunction

	// Applies one request to the shadow list and returns its response
	function automatic list_response_t apply_request(input list_request_t rq);
		list_response_t outcome;
		int slot;
		int at;
		int pos;
		outcome.read_value = NO_VALUE;
		outcome.status     = ST_DONE;
		case (rq.opcode)
			OP_HEAD, OP_TAIL, OP_AFTER: begin
				at = (rq.opcode == OP_TAIL) ? list_len : 0;
				// negative, then duplicate, then anchor, then capacity
				if (rq.value[DATA_W-1] || find_entry(rq.value) >= 0) begin
					outcome.status = ST_IGNORED;
				end else if (rq.opcode == OP_AFTER) begin
					slot = find_entry(rq.anchor);
					if (slot < 0)
						outcome.status = ST_IGNORED;
					else
						at = slot + 1;
				end
				if (outcome.status == ST_DONE) begin
					if (list_len >= CAPACITY) begin
						outcome.status = ST_FULL;
					end else begin
						for (int i = list_len; i > at; i--)
							list_store[i] = list_store[i-1];
						list_store[at] = rq.value[ENTRY_W-1:0];
						list_len++;
					end
				end
			end
			OP_REMOVE: begin
				slot = find_entry(rq.value);
				if (slot < 0) begin
					outcome.status = ST_IGNORED;
				end else begin
					for (int i = slot; i < list_len - 1; i++)
						list_store[i] = list_store[i+1];
					list_len--;
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			OP_READ: begin
				pos = rq.position;
				if (pos >= 0 && pos < list_len)
					outcome.read_value = {1'b0, list_store[pos]};
				else
					outcome.status = ST_IGNORED;
			end
			default: begin
				outcome.status = ST_IGNORED;
			end
		endcase
		outcome.entry_count = list_len[COUNT_W-1:0];
		return outcome;
	endfunction

	// Offers one request, with random idle cycles first, and records its response
	task automatic send_request(input logic [OPCODE_W-1:0] opcode,
		input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] anchor,
		input logic [DATA_W-1:0] position);
		list_request_t rq;
		rq.opcode   = opcode;
		rq.value    = value;
		rq.anchor   = anchor;
		rq.position = position;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.opcode   <= opcode;
		req.value    <= value;
		req.anchor   <= anchor;
		req.position <= position;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		expected_responses.push_back(apply_request(rq));
	endtask

	// Holds off until every outstanding response has come back
	task automatic drain_responses();
		req.valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field,
		input logic signed [DATA_W-1:0] expected_v,
		input logic signed [DATA_W-1:0] actual_v);
		if (actual_v !== expected_v) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, expected_v, actual_v);
		end
	endtask

	// Random stall on the response side
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Response checker
	always @(posedge clk) begin
		list_response_t exp_rsp;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_responses.size() == 0) begin
				mismatches++;
				$display("%0t: response with none pending: read_value %0d count %0d status %0d",
					$time, rsp.read_value, rsp.entry_count, rsp.status);
			end else begin
				exp_rsp = expected_responses.pop_front();
				check_field("read_value", $signed(exp_rsp.read_value), rsp.read_value);
				check_field("entry_count", DATA_W'(exp_rsp.entry_count),
					DATA_W'(rsp.entry_count));
				check_field("status", DATA_W'(exp_rsp.status), DATA_W'(rsp.status));
			end
		end
	end

	// Reads and removes on an empty list
	task automatic test_empty_list();
		send_request(OP_READ, 32'd0, 32'd0, 32'd0);
		send_request(OP_REMOVE, 32'd5, 32'd0, 32'd0);
	endtask

	// Insert variants and the reasons an insert is ignored
	task automatic test_insert_rules();
		send_request(OP_HEAD, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_TAIL, 32'h7FFF_FFFF, 32'd0, 32'd0);
		send_request(OP_AFTER, 32'd100, 32'd0, 32'd0);
		send_request(OP_HEAD, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_request(OP_TAIL, 32'h8000_0000, 32'd0, 32'd0);
		send_request(OP_AFTER, 32'd100, 32'h7FFF_FFFF, 32'd0);
		send_request(OP_AFTER, 32'd200, 32'd55, 32'd0);
		send_request(OP_AFTER, 32'd200, 32'hFFFF_FFFF, 32'd0);
	endtask

	// Reads in and out of range, removes, unused opcodes
	task automatic test_read_and_remove();
		send_request(OP_READ, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_request(OP_READ, 32'd0, 32'd0, 32'd3);
		send_request(OP_READ, 32'd0, 32'd0, 32'd2);
		send_request(OP_REMOVE, 32'd100, 32'd0, 32'd0);
		send_request(OP_REMOVE, 32'hFFFF_FFFB, 32'd0, 32'd0);
		send_request(3'd6, 32'd0, 32'd0, 32'd0);
		send_request(3'd7, 32'd0, 32'd0, 32'd0);
	endtask

	// Fill to capacity, then hit the full list with each insert outcome
	task automatic test_full_list();
		int n;
		n = 0;
		while (list_len < CAPACITY) begin
			case (n % 3)
				0: send_request(OP_HEAD, 32'd1000 + n, 32'd0, 32'd0);
				1: send_request(OP_TAIL, 32'd1000 + n, 32'd0, 32'd0);
				default: send_request(OP_AFTER, 32'd1000 + n, 32'd1000, 32'd0);
			endcase
			n++;
		end
		send_request(OP_HEAD, 32'd5000, 32'd0, 32'd0);
		send_request(OP_TAIL, 32'd0, 32'd0, 32'd0);
		send_request(OP_AFTER, 32'd5001, 32'd9999, 32'd0);
		send_request(OP_READ, 32'd0, 32'd0, CAPACITY - 1);
		send_request(OP_CLEAR, 32'd0, 32'd0, 32'd0);
		send_request(OP_READ, 32'd0, 32'd0, 32'd0);
	endtask

	// Mostly small values so that duplicates, hits and a full list are common
	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(31);
		else if (r < 90)
			return $urandom & 32'h7FFF_FFFF;
		else
			return $urandom;
	endfunction

	task automatic test_random_traffic(input int n_items);
		int r;
		logic [OPCODE_W-1:0] opcode;
		logic [DATA_W-1:0]   anchor;
		logic [DATA_W-1:0]   position;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(99);
			if (r < 22)
				opcode = OP_HEAD;
			else if (r < 44)
				opcode = OP_TAIL;
			else if (r < 56)
				opcode = OP_AFTER;
			else if (r < 74)
				opcode = OP_REMOVE;
			else if (r < 95)
				opcode = OP_READ;
			else if (r < 97)
				opcode = OP_CLEAR;
			else
				opcode = OPCODE_W'($urandom_range(7, 6));
			// anchor mostly an entry already held
			if (list_len > 0 && $urandom_range(99) < 60)
				anchor = {1'b0, list_store[$urandom_range(list_len - 1)]};
			else
				anchor = ($urandom_range(1) == 0) ? pick_value() : $urandom;
			// position mostly within or just past the count
			if ($urandom_range(99) < 75)
				position = $urandom_range(list_len);
			else
				position = $urandom;
			send_request(opcode, pick_value(), anchor, position);
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.opcode   <= '0;
		req.value    <= '0;
		req.anchor   <= '0;
		req.position <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		stall_pct     = 64;
		test_empty_list();
		test_insert_rules();
		test_read_and_remove();
		test_full_list();
		test_random_traffic(350);
		drain_responses();

		send_idle_pct = 64;
		stall_pct     = 8;
		test_random_traffic(350);
		drain_responses();

		send_idle_pct = 0;
		stall_pct     = 0;
		test_random_traffic(350);

		// Wind down: wait for outstanding responses, then a little longer
		req.valid <= 1'b0;
		for (wait_cycles = 0; expected_responses.size() != 0 && wait_cycles < 5000;
			wait_cycles++)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (expected_responses.size() != 0) begin
			mismatches++;
			$display("%0t: %0d responses never arrived", $time, expected_responses.size());
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/oule_pkg.sv
hw/rtl/oule_req_if.sv
hw/rtl/oule_rsp_if.sv
hw/rtl/ordered_unique_list_engine.sv
verif/tb.sv
